@@ rtl/ipv4rt_pkg.sv @@
// Shared types, constants and helpers of the IPv4 prefix route table.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package ipv4rt_pkg;

  localparam int ADDR_BITS       = 32;
  localparam int LEN_W           = 6;
  localparam int PORT_W          = 8;
  localparam int NIC_W           = 9;
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] prefix;
    logic [LEN_W-1:0]     length;
    logic [PORT_W-1:0]    port;
  } entry_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctl_t;

  // Result of the compare unit back to the sequencer.
  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] port;
  } cmp_res_t;

  // Network mask for a prefix length of 0 to 32; zero length gives an empty mask.
  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_BITS-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipv4rt_if.sv @@
// Request and reply channel interfaces of the IPv4 prefix route table.
// Depends on ipv4rt_pkg for field widths.
`default_nettype none

interface ipv4rt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [ipv4rt_pkg::ADDR_BITS-1:0]    address;
  logic [ipv4rt_pkg::LEN_W-1:0]        prefix_length;
  logic [ipv4rt_pkg::PORT_W-1:0]       interface_id;
  logic [31:0]                         packet_id;

  modport source (output valid, action, address, prefix_length, interface_id, packet_id,
                  input ready);
  modport sink (input valid, action, address, prefix_length, interface_id, packet_id,
                output ready);
endinterface

interface ipv4rt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          reply_kind;
  logic [31:0]                   packet_tag;
  logic                          route_found;
  logic [ipv4rt_pkg::PORT_W-1:0] out_interface;
  logic                          insert_accepted;
  logic [31:0]                   forwarded_total;
  logic [31:0]                   dropped_total;

  modport source (output valid, reply_kind, packet_tag, route_found, out_interface,
                  insert_accepted, forwarded_total, dropped_total,
                  input ready);
  modport sink (input valid, reply_kind, packet_tag, route_found, out_interface,
                insert_accepted, forwarded_total, dropped_total,
                output ready);
endinterface

`default_nettype wire

@@ rtl/ipv4_prefix_route_table.sv @@
// IPv4 longest prefix match route table, top level: sequencer, entry store, compare unit.
// Insert request: the reply is built in DONE; the next request is taken back in IDLE.
// Lookup request: N stored entries are read one per cycle through the single memory read
// port and compared in turn, then the reply is built in DONE; the next request is taken
// once the sequencer is back in IDLE.
// Synchronous active-low reset empties the table, clears counters and nic_count; no sweep.
`default_nettype none

module ipv4_prefix_route_table #(
  parameter int TABLE_DEPTH = ipv4rt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  ipv4rt_req_if.sink                        in_req,
  ipv4rt_rsp_if.source                      out_rsp,
  input  wire logic                         cfg_we,
  input  wire logic [ipv4rt_pkg::NIC_W-1:0] cfg_wdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // One-hot sequencer states. SCAN streams the table through the compare unit;
  // DONE holds a finished reply until the output register is free.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration register.
  logic [ipv4rt_pkg::NIC_W-1:0] nic_count_r;

  // Table fill level and scan read pointer.
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;

  // Captured request.
  logic                             kind_r, kind_nxt;
  logic                             accepted_r, accepted_nxt;
  logic [ipv4rt_pkg::ADDR_BITS-1:0] dest_r, dest_nxt;
  logic [31:0]                      pid_r, pid_nxt;

  // Packet counters.
  logic [31:0] fwd_r, fwd_nxt;
  logic [31:0] drop_r, drop_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic                          o_kind_r, o_kind_nxt;
  logic [31:0]                   o_tag_r, o_tag_nxt;
  logic                          o_found_r, o_found_nxt;
  logic [ipv4rt_pkg::PORT_W-1:0] o_port_r, o_port_nxt;
  logic                          o_acc_r, o_acc_nxt;
  logic [31:0]                   o_fwd_r, o_fwd_nxt;
  logic [31:0]                   o_drop_r, o_drop_nxt;

  // Handshake and datapath nets.
  logic                          in_fire;
  logic                          out_free;
  logic                          can_insert;
  logic [ipv4rt_pkg::LEN_W-1:0]  sat_len;
  logic [ipv4rt_pkg::NIC_W-1:0]  nic_max;
  logic [ipv4rt_pkg::PORT_W-1:0] clamp_port;
  logic                          wr_en;
  ipv4rt_pkg::entry_t            wr_data;
  logic                          rd_en;
  ipv4rt_pkg::entry_t            rd_data;
  logic                          rd_vld;
  ipv4rt_pkg::cmp_ctl_t          cmp_ctl;
  ipv4rt_pkg::cmp_res_t          cmp_res;

  // A new request is taken whenever the sequencer is idle, even if the previous reply
  // still waits in the output register; DONE then holds until that register empties.
  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // Insert path: saturate the length, clamp the interface to nic_count-1, and store
  // the prefix with its host bits cleared. The write happens in the accepting cycle.
  assign can_insert = (total_r < DEPTH_C) && (nic_count_r != '0);
  assign sat_len    = (in_req.prefix_length > ipv4rt_pkg::LEN_W'(ipv4rt_pkg::ADDR_BITS)) ?
                      ipv4rt_pkg::LEN_W'(ipv4rt_pkg::ADDR_BITS) : in_req.prefix_length;
  assign nic_max    = nic_count_r - ipv4rt_pkg::NIC_W'(1);
  assign clamp_port = ({1'b0, in_req.interface_id} > nic_max) ?
                      nic_max[ipv4rt_pkg::PORT_W-1:0] : in_req.interface_id;

  assign wr_en          = in_fire && (in_req.action == ipv4rt_pkg::ACT_INSERT) && can_insert;
  assign wr_data.prefix = in_req.address & ipv4rt_pkg::prefix_mask(sat_len);
  assign wr_data.length = sat_len;
  assign wr_data.port   = clamp_port;

  // Scan path: one entry read per cycle; the compare unit sees each entry in the cycle
  // after its read, aligned with the registered read data.
  assign rd_en       = (state_r == S_SCAN) && (rd_cnt_r < total_r);
  assign cmp_ctl.clear = in_fire;
  assign cmp_ctl.en    = rd_vld;

  ipv4rt_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_idx    (total_r[IDX_W-1:0]),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_idx    (rd_cnt_r[IDX_W-1:0]),
    .rd_data_r (rd_data),
    .rd_vld_r  (rd_vld)
  );

  ipv4rt_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cmp_ctl),
    .dest  (dest_r),
    .entry (rd_data),
    .res   (cmp_res)
  );

  // Sequencer and reply assembly.
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    rd_cnt_nxt    = rd_cnt_r;
    kind_nxt      = kind_r;
    accepted_nxt  = accepted_r;
    dest_nxt      = dest_r;
    pid_nxt       = pid_r;
    fwd_nxt       = fwd_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    o_kind_nxt    = o_kind_r;
    o_tag_nxt     = o_tag_r;
    o_found_nxt   = o_found_r;
    o_port_nxt    = o_port_r;
    o_acc_nxt     = o_acc_r;
    o_fwd_nxt     = o_fwd_r;
    o_drop_nxt    = o_drop_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt     = in_req.action;
          dest_nxt     = in_req.address;
          pid_nxt      = in_req.packet_id;
          accepted_nxt = wr_en;
          rd_cnt_nxt   = '0;
          if (in_req.action == ipv4rt_pkg::ACT_INSERT) begin
            if (wr_en) begin
              total_nxt = total_r + CNT_W'(1);
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end else if (!rd_vld) begin
          // Every entry has been read and the last one compared.
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = kind_r;
          if (kind_r == ipv4rt_pkg::ACT_LOOKUP) begin
            o_tag_nxt   = pid_r;
            o_found_nxt = cmp_res.found;
            o_port_nxt  = cmp_res.port;
            o_acc_nxt   = 1'b0;
            if (cmp_res.found) begin
              fwd_nxt = fwd_r + 32'd1;
            end else begin
              drop_nxt = drop_r + 32'd1;
            end
          end else begin
            o_tag_nxt   = '0;
            o_found_nxt = 1'b0;
            o_port_nxt  = '0;
            o_acc_nxt   = accepted_r;
          end
          o_fwd_nxt  = fwd_nxt;
          o_drop_nxt = drop_nxt;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      rd_cnt_r    <= '0;
      fwd_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
      nic_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      fwd_r       <= fwd_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        nic_count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    accepted_r <= accepted_nxt;
    dest_r     <= dest_nxt;
    pid_r      <= pid_nxt;
    o_kind_r   <= o_kind_nxt;
    o_tag_r    <= o_tag_nxt;
    o_found_r  <= o_found_nxt;
    o_port_r   <= o_port_nxt;
    o_acc_r    <= o_acc_nxt;
    o_fwd_r    <= o_fwd_nxt;
    o_drop_r   <= o_drop_nxt;
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.reply_kind      = o_kind_r;
  assign out_rsp.packet_tag      = o_tag_r;
  assign out_rsp.route_found     = o_found_r;
  assign out_rsp.out_interface   = o_port_r;
  assign out_rsp.insert_accepted = o_acc_r;
  assign out_rsp.forwarded_total = o_fwd_r;
  assign out_rsp.dropped_total   = o_drop_r;

endmodule

`default_nettype wire

@@ rtl/ipv4rt_table.sv @@
// Entry store of the route table: one write port and one registered read port.
// Depends on ipv4rt_pkg for the entry type.
`default_nettype none

module ipv4rt_table #(
  parameter int DEPTH = ipv4rt_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_idx,
  input  wire ipv4rt_pkg::entry_t wr_data,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_idx,
  output ipv4rt_pkg::entry_t      rd_data_r,
  output logic                    rd_vld_r
);

  ipv4rt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Marks the cycle in which rd_data_r holds a freshly read entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ipv4rt_match.sv @@
// Shared masked compare unit that keeps the best match seen during a scan.
// Depends on ipv4rt_pkg for the entry, control and result types.
`default_nettype none

module ipv4rt_match (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ipv4rt_pkg::cmp_ctl_t             ctl,
  input  wire logic [ipv4rt_pkg::ADDR_BITS-1:0] dest,
  input  wire ipv4rt_pkg::entry_t               entry,
  output ipv4rt_pkg::cmp_res_t                  res
);

  logic                          found_r, found_nxt;
  logic [ipv4rt_pkg::LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [ipv4rt_pkg::PORT_W-1:0] port_r, port_nxt;
  logic                          hit;

  // Entries arrive in insertion order, so ">=" lets the latest equal entry win.
  assign hit = ((dest & ipv4rt_pkg::prefix_mask(entry.length)) == entry.prefix) &&
               (!found_r || (entry.length >= best_len_r));

  always_comb begin
    found_nxt    = found_r;
    best_len_nxt = best_len_r;
    port_nxt     = port_r;
    if (ctl.clear) begin
      found_nxt    = 1'b0;
      best_len_nxt = '0;
      port_nxt     = '0;
    end else if (ctl.en && hit) begin
      found_nxt    = 1'b1;
      best_len_nxt = entry.length;
      port_nxt     = entry.port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_len_r <= best_len_nxt;
    port_r     <= port_nxt;
  end

  assign res.found = found_r;
  assign res.port  = port_r;

endmodule

`default_nettype wire
